// ===== rtl/three_phase_dq_transform_top_defines.svh =====
// Assertion macros shared by the checker.
`ifndef THREE_PHASE_DQ_TRANSFORM_TOP_DEFINES_SVH
`define THREE_PHASE_DQ_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TPDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpdq: implication check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define TPDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpdq: next-cycle check failed");

`endif

// ===== rtl/tpdq_pkg.sv =====
package tpdq_pkg;

  // Q4.30 working width of the sine polynomial (34 bits, sign included)
  localparam int unsigned TW = 34;
  typedef logic signed [TW-1:0] fix_t;

  // sine and cosine in Q24, +/-1.0 inclusive
  localparam int unsigned TRIG_W = 26;
  typedef logic signed [TRIG_W-1:0] trig_t;
  localparam trig_t TRIG_ONE = 26'sd16777216;

  // odd-power coefficients of the quarter-wave sine, Q30
  localparam fix_t HC1 = 34'sd1686629713;
  localparam fix_t HC3 = -34'sd693598668;
  localparam fix_t HC5 = 34'sd85569306;
  localparam fix_t HC7 = -34'sd5026995;
  localparam fix_t HC9 = 34'sd172272;

  localparam int unsigned NUM_CELLS = 4;
  localparam fix_t HORNER_COEF [NUM_CELLS] = '{HC7, HC5, HC3, HC1};

  localparam logic signed [24:0] INV_SQRT3_Q24 = 25'sd9686330;
  localparam logic signed [25:0] SQRT3_Q24     = 26'sd29058991;

  localparam int unsigned NUM_LANES = 2;
  localparam int unsigned LANE_SIN  = 0;
  localparam int unsigned LANE_COS  = 1;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_e;

  // one trig lane as it moves down the polynomial chain
  typedef struct packed {
    fix_t r;
    fix_t r2;
    fix_t p;
    logic neg;
    logic full;
  } lane_t;

  localparam logic signed [2*TW-1:0] RND30 = 68'sd536870912;

  // Q30 product, rounded half up
  function automatic fix_t mul30(input fix_t a, input fix_t b);
    logic signed [2*TW-1:0] prod;
    prod = a * b;
    prod = prod + RND30;
    return fix_t'(prod >>> 30);
  endfunction

endpackage

// ===== rtl/tpdq_if.sv =====
interface tpdq_in_if #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned ANGLE_BITS  = 12
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] phase_u;
  logic signed [SAMPLE_BITS-1:0] phase_v;
  logic signed [SAMPLE_BITS-1:0] phase_w;
  logic signed [SAMPLE_BITS-1:0] in_direct;
  logic signed [SAMPLE_BITS-1:0] in_quadrature;
  logic [ANGLE_BITS-1:0]         angle;

  modport source (
    output valid, op, phase_u, phase_v, phase_w, in_direct, in_quadrature, angle,
    input  ready
  );
  modport sink (
    input  valid, op, phase_u, phase_v, phase_w, in_direct, in_quadrature, angle,
    output ready
  );
endinterface

interface tpdq_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_alpha;
  logic signed [SAMPLE_BITS-1:0] out_beta;
  logic signed [SAMPLE_BITS-1:0] out_direct;
  logic signed [SAMPLE_BITS-1:0] out_quadrature;
  logic signed [SAMPLE_BITS-1:0] out_u;
  logic signed [SAMPLE_BITS-1:0] out_v;
  logic signed [SAMPLE_BITS-1:0] out_w;
  logic                          saturated;

  modport source (
    output valid, out_alpha, out_beta, out_direct, out_quadrature,
           out_u, out_v, out_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_alpha, out_beta, out_direct, out_quadrature,
           out_u, out_v, out_w, saturated,
    output ready
  );
endinterface

// ===== rtl/tpdq_horner_cell.sv =====
module tpdq_horner_cell
  import tpdq_pkg::*;
#(
  parameter fix_t COEF = 34'sd0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  lane_t [NUM_LANES-1:0]  lane_i,
  output lane_t [NUM_LANES-1:0]  lane_o
);

  lane_t [NUM_LANES-1:0] lane_d;
  lane_t [NUM_LANES-1:0] lane_q;

  // p <- COEF + p * r^2, both lanes
  always_comb begin
    lane_d = lane_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_d[l].p = COEF + mul30(lane_i[l].p, lane_i[l].r2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== rtl/three_phase_dq_transform_top.sv =====
// Clarke/Park transform, forward (abc -> dq) and inverse (dq -> abc).
// Pipeline: 12 register stages, from the stage 0 capture to the stage 11 output register.
// Throughput: one word per cycle; the whole pipeline stalls only while the output word waits.
// Multipliers are spread over the stages; sine polynomial as a row of Horner cells.
// Reset: rst_ni asynchronous, active low; clears stage valids only, no words in flight after.
module three_phase_dq_transform_top
  import tpdq_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned ANGLE_BITS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpdq_in_if.sink     in_i,
  tpdq_out_if.source  out_o
);

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned A    = ANGLE_BITS;
  localparam int unsigned WW   = S + 28;   // headroom for all result sums
  localparam int unsigned PW   = S + 26;   // sample times Q24 constant
  localparam int unsigned LAST = 11;

  localparam logic [A-1:0] QUARTER   = A'(1) << (A-2);
  localparam logic [A-2:0] QUARTER_F = (A-1)'(1) << (A-2);

  localparam logic signed [WW-1:0] HALF24 = WW'(1) << 23;
  localparam logic signed [WW-1:0] HALF25 = WW'(1) << 24;
  localparam logic signed [WW-1:0] SMAX_W = (WW'(1) << (S-1)) - WW'(1);
  localparam logic signed [WW-1:0] SMIN_W = -SMAX_W - WW'(1);
  localparam fix_t                 RND6   = 34'sd32;

  typedef logic signed [S-1:0]  samp_t;
  typedef logic signed [PW-1:0] prod_t;

  // round half up by 24 (or 25 when half is set), then clip; MSB is the clip flag
  function automatic logic [S:0] rnd_clip(input logic signed [WW-1:0] x, input logic half);
    logic signed [WW-1:0] r;
    logic                 sat;
    samp_t                v;
    r = half ? ((x + HALF25) >>> 25) : ((x + HALF24) >>> 24);
    if (r > SMAX_W) begin
      sat = 1'b1;
      v   = samp_t'(SMAX_W);
    end else if (r < SMIN_W) begin
      sat = 1'b1;
      v   = samp_t'(SMIN_W);
    end else begin
      sat = 1'b0;
      v   = samp_t'(r);
    end
    return {sat, v};
  endfunction

  // ---------------------------------------------------------------------------
  // Global stall: everything moves unless the output word is held
  // ---------------------------------------------------------------------------
  logic           en;
  logic [LAST:0]  vld_q;

  assign en         = !vld_q[LAST] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], in_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: capture word, fold angles into first quadrant (sine and cosine)
  // ---------------------------------------------------------------------------
  logic [A-1:0]           ang_idx [NUM_LANES];
  logic [1:0]             quad    [NUM_LANES];
  logic [A-2:0]           frac    [NUM_LANES];
  lane_t [NUM_LANES-1:0]  lane0_d;
  lane_t [NUM_LANES-1:0]  lane0_q;
  op_e                    op0_q;
  samp_t                  pu0_q, pv0_q, pw0_q, id0_q, iq0_q;

  always_comb begin
    ang_idx[LANE_SIN] = in_i.angle;
    ang_idx[LANE_COS] = in_i.angle + QUARTER;   // cos(x) = sin(x + quarter)
    for (int l = 0; l < NUM_LANES; l++) begin
      quad[l] = ang_idx[l][A-1:A-2];
      // odd quadrants run backwards from the quarter
      frac[l] = quad[l][0] ? (QUARTER_F - {1'b0, ang_idx[l][A-3:0]})
                           : {1'b0, ang_idx[l][A-3:0]};
      lane0_d[l].r    = fix_t'(frac[l]) << (32 - A);
      lane0_d[l].r2   = '0;
      lane0_d[l].p    = '0;
      lane0_d[l].neg  = quad[l][1];
      lane0_d[l].full = frac[l][A-2];           // exactly a quarter: sine is 1.0
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane0_q <= lane0_d;
      op0_q   <= op_e'(in_i.op);
      pu0_q   <= in_i.phase_u;
      pv0_q   <= in_i.phase_v;
      pw0_q   <= in_i.phase_w;
      id0_q   <= in_i.in_direct;
      iq0_q   <= in_i.in_quadrature;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: r^2, seed the polynomial; forward beta product
  // ---------------------------------------------------------------------------
  lane_t [NUM_LANES-1:0]  lane1_d;
  lane_t [NUM_LANES-1:0]  lane1_q;
  logic signed [S:0]      diff0;
  prod_t                  prod1_d;
  prod_t                  prod1_q;
  samp_t                  x1_q, iq1_q;
  op_e                    op1_q;

  always_comb begin
    lane1_d = lane0_q;
    for (int l = 0; l < NUM_LANES; l++) begin
      lane1_d[l].r2 = mul30(lane0_q[l].r, lane0_q[l].r);
      lane1_d[l].p  = HC9;
    end
  end

  assign diff0   = (S+1)'(pv0_q) - (S+1)'(pw0_q);
  assign prod1_d = INV_SQRT3_Q24 * diff0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane1_q <= lane1_d;
      prod1_q <= prod1_d;
      x1_q    <= (op0_q == OP_INV) ? id0_q : pu0_q;   // forward alpha is u, unclipped
      iq1_q   <= iq0_q;
      op1_q   <= op0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2..5: row of Horner cells, one coefficient each
  // ---------------------------------------------------------------------------
  lane_t [NUM_LANES-1:0] cell_lane [0:NUM_CELLS];

  assign cell_lane[0] = lane1_q;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    tpdq_horner_cell #(
      .COEF (HORNER_COEF[k])
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (cell_lane[k]),
      .lane_o (cell_lane[k+1])
    );
  end

  // Operands ride a delay line from stage 2 to meet the trig values at stage 7
  logic [S:0] beta_rc;
  samp_t      xd_q   [2:7];
  samp_t      yd_q   [2:7];
  op_e        opd_q  [2:7];
  logic       satd_q [2:7];

  assign beta_rc = rnd_clip(WW'(prod1_q), 1'b0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q[2]   <= x1_q;
      yd_q[2]   <= (op1_q == OP_INV) ? iq1_q : beta_rc[S-1:0];
      opd_q[2]  <= op1_q;
      satd_q[2] <= (op1_q == OP_INV) ? 1'b0 : beta_rc[S];
      for (int k = 3; k <= 7; k++) begin
        xd_q[k]   <= xd_q[k-1];
        yd_q[k]   <= yd_q[k-1];
        opd_q[k]  <= opd_q[k-1];
        satd_q[k] <= satd_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: final multiply by r; stage 7: Q24, quadrant sign
  // ---------------------------------------------------------------------------
  fix_t              t6_q    [NUM_LANES];
  logic [NUM_LANES-1:0] neg6_q, full6_q;
  fix_t              rnd6    [NUM_LANES];
  trig_t             mag7    [NUM_LANES];
  trig_t             trig7_q [NUM_LANES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        t6_q[l]    <= mul30(cell_lane[NUM_CELLS][l].p, cell_lane[NUM_CELLS][l].r);
        neg6_q[l]  <= cell_lane[NUM_CELLS][l].neg;
        full6_q[l] <= cell_lane[NUM_CELLS][l].full;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rnd6[l] = (t6_q[l] + RND6) >>> 6;
      mag7[l] = full6_q[l] ? TRIG_ONE : trig_t'(rnd6[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trig7_q[l] <= neg6_q[l] ? -mag7[l] : mag7[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: rotation products; stage 9: sums, round, clip
  // ---------------------------------------------------------------------------
  prod_t  m8_q [4];
  samp_t  x8_q, y8_q;
  op_e    op8_q;
  logic   sat8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m8_q[0] <= xd_q[7] * trig7_q[LANE_COS];
      m8_q[1] <= yd_q[7] * trig7_q[LANE_SIN];
      m8_q[2] <= yd_q[7] * trig7_q[LANE_COS];
      m8_q[3] <= xd_q[7] * trig7_q[LANE_SIN];
      x8_q    <= xd_q[7];
      y8_q    <= yd_q[7];
      op8_q   <= opd_q[7];
      sat8_q  <= satd_q[7];
    end
  end

  logic signed [WW-1:0] sum1, sum2;
  logic [S:0]           rc1, rc2;

  // forward: d = x.c - y.s, q = y.c + x.s; inverse: alpha = x.c + y.s, beta = y.c - x.s
  always_comb begin
    if (op8_q == OP_INV) begin
      sum1 = WW'(m8_q[0]) + WW'(m8_q[1]);
      sum2 = WW'(m8_q[2]) - WW'(m8_q[3]);
    end else begin
      sum1 = WW'(m8_q[0]) - WW'(m8_q[1]);
      sum2 = WW'(m8_q[2]) + WW'(m8_q[3]);
    end
    rc1 = rnd_clip(sum1, 1'b0);
    rc2 = rnd_clip(sum2, 1'b0);
  end

  samp_t r1_9_q, r2_9_q, x9_q, y9_q;
  op_e   op9_q;
  logic  sat9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_9_q <= rc1[S-1:0];
      r2_9_q <= rc2[S-1:0];
      x9_q   <= x8_q;
      y9_q   <= y8_q;
      op9_q  <= op8_q;
      sat9_q <= sat8_q | rc1[S] | rc2[S];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: sqrt3 * beta for inverse Clarke
  // ---------------------------------------------------------------------------
  prod_t k10_q;
  samp_t r1_10_q, r2_10_q, x10_q, y10_q;
  op_e   op10_q;
  logic  sat10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k10_q   <= SQRT3_Q24 * r2_9_q;
      r1_10_q <= r1_9_q;
      r2_10_q <= r2_9_q;
      x10_q   <= x9_q;
      y10_q   <= y9_q;
      op10_q  <= op9_q;
      sat10_q <= sat9_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 11: inverse Clarke halves, output register
  // ---------------------------------------------------------------------------
  logic signed [WW-1:0] a_w, k_w;
  logic [S:0]           rcv, rcw;

  assign a_w = WW'(r1_10_q) <<< 24;
  assign k_w = WW'(k10_q);
  assign rcv = rnd_clip(-a_w + k_w, 1'b1);
  assign rcw = rnd_clip(-a_w - k_w, 1'b1);

  samp_t oa_q, ob_q, od_q, oq_q, ou_q, ov_q, ow_q;
  logic  osat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (op10_q == OP_INV) begin
        oa_q   <= r1_10_q;
        ob_q   <= r2_10_q;
        od_q   <= '0;
        oq_q   <= '0;
        ou_q   <= r1_10_q;
        ov_q   <= rcv[S-1:0];
        ow_q   <= rcw[S-1:0];
        osat_q <= sat10_q | rcv[S] | rcw[S];
      end else begin
        oa_q   <= x10_q;
        ob_q   <= y10_q;
        od_q   <= r1_10_q;
        oq_q   <= r2_10_q;
        ou_q   <= '0;
        ov_q   <= '0;
        ow_q   <= '0;
        osat_q <= sat10_q;
      end
    end
  end

  assign out_o.valid          = vld_q[LAST];
  assign out_o.out_alpha      = oa_q;
  assign out_o.out_beta       = ob_q;
  assign out_o.out_direct     = od_q;
  assign out_o.out_quadrature = oq_q;
  assign out_o.out_u          = ou_q;
  assign out_o.out_v          = ov_q;
  assign out_o.out_w          = ow_q;
  assign out_o.saturated      = osat_q;

endmodule

// ===== rtl/tpdq_checker.sv =====
`include "three_phase_dq_transform_top_defines.svh"

module tpdq_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_alpha_i,
  input logic [SAMPLE_BITS-1:0] out_beta_i,
  input logic [SAMPLE_BITS-1:0] out_direct_i,
  input logic [SAMPLE_BITS-1:0] out_quadrature_i,
  input logic [SAMPLE_BITS-1:0] out_u_i,
  input logic [SAMPLE_BITS-1:0] out_v_i,
  input logic [SAMPLE_BITS-1:0] out_w_i
);

  `TPDQ_ASSERT_NXT(a_out_valid_held, out_valid_i && !out_ready_i, out_valid_i)
  `TPDQ_ASSERT_NXT(a_out_word_held, out_valid_i && !out_ready_i, $stable(out_alpha_i) && $stable(out_beta_i) && $stable(out_u_i))
  // held output word stalls the whole pipe, input too
  `TPDQ_ASSERT_IMP(a_stall_blocks_input, out_valid_i && !out_ready_i, !in_ready_i)
  // one mode's fields are always zero
  `TPDQ_ASSERT_IMP(a_mode_zeros, out_valid_i, (out_u_i == '0 && out_v_i == '0 && out_w_i == '0) || (out_direct_i == '0 && out_quadrature_i == '0))
  // inverse: reconstructed U is alpha
  `TPDQ_ASSERT_IMP(a_u_is_alpha, out_valid_i && out_u_i != '0, out_u_i == out_alpha_i)

endmodule

bind three_phase_dq_transform_top tpdq_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_tpdq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_alpha_i      (out_o.out_alpha),
  .out_beta_i       (out_o.out_beta),
  .out_direct_i     (out_o.out_direct),
  .out_quadrature_i (out_o.out_quadrature),
  .out_u_i          (out_o.out_u),
  .out_v_i          (out_o.out_v),
  .out_w_i          (out_o.out_w)
);

// ===== dv/tb_three_phase_dq_transform_top.sv =====
module tb_three_phase_dq_transform_top;
  import tpdq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 16;
  localparam int AB = 12;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;
  localparam int QUARTER = 1 << (AB - 2);
  localparam int N_RANDOM = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tpdq_in_if  #(.SAMPLE_BITS(SB), .ANGLE_BITS(AB)) in_if ();
  tpdq_out_if #(.SAMPLE_BITS(SB)) out_if ();

  three_phase_dq_transform_top #(.SAMPLE_BITS(SB), .ANGLE_BITS(AB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one input word
  typedef struct {
    op_e             op;
    logic [SB-1:0]   pu, pv, pw, id, iq;
    logic [AB-1:0]   ang;
  } xform_in_t;

  // one output word
  typedef struct {
    logic [SB-1:0] alpha, beta, d, q, u, v, w;
    logic          sat;
  } xform_out_t;

  // directed row: a word, plus an optional hand-typed answer
  typedef struct {
    xform_in_t  stim;
    bit         typed;
    xform_out_t res;
  } dir_row_t;

  xform_out_t dq_expected[$];
  int         n_fail = 0;
  bit         sink_hold = 1'b0;     // long receiver hold-off in progress
  bit         quiet_gaps = 1'b0;    // stretch with no idling

  // ---------------------------------------------------------------------
  // Predictor: Q30 sine polynomial, Q24 trig, half-up rounding, clipping
  // ---------------------------------------------------------------------
  function automatic longint rshift_half_up(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint sin_quadrant(int f);
    longint r, r2, p;
    if (f >= QUARTER) return longint'(1) << 30;
    r  = longint'(f) << (32 - AB);
    r2 = rshift_half_up(r * r, 30);
    p  = 172272;
    p  = -5026995   + rshift_half_up(p * r2, 30);
    p  = 85569306   + rshift_half_up(p * r2, 30);
    p  = -693598668 + rshift_half_up(p * r2, 30);
    p  = 1686629713 + rshift_half_up(p * r2, 30);
    return rshift_half_up(p * r, 30);
  endfunction

  function automatic longint sine_q24(int idx);
    int quad, f;
    longint m;
    idx  = idx & ((1 << AB) - 1);
    quad = (idx >> (AB - 2)) & 3;
    f    = idx & (QUARTER - 1);
    if (quad & 1) f = QUARTER - f;
    m = rshift_half_up(sin_quadrant(f), 6);
    return (quad & 2) ? -m : m;
  endfunction

  function automatic longint clip16(longint x, ref bit flag);
    if (x > SMAX) begin flag = 1'b1; return SMAX; end
    if (x < SMIN) begin flag = 1'b1; return SMIN; end
    return x;
  endfunction

  function automatic xform_out_t predict_dq(xform_in_t x);
    xform_out_t o;
    bit sat;
    longint s, c, al, be, d, q, u, v, w;
    sat = 1'b0;
    d = 0; q = 0; u = 0; v = 0; w = 0;
    s = sine_q24(x.ang);
    c = sine_q24(int'(x.ang) + QUARTER);
    if (x.op == OP_FWD) begin
      al = longint'($signed(x.pu));
      be = clip16(rshift_half_up(64'sd9686330 *
             (longint'($signed(x.pv)) - longint'($signed(x.pw))), 24), sat);
      d  = clip16(rshift_half_up(al * c - be * s, 24), sat);
      q  = clip16(rshift_half_up(be * c + al * s, 24), sat);
    end else begin
      al = clip16(rshift_half_up(longint'($signed(x.id)) * c +
                                 longint'($signed(x.iq)) * s, 24), sat);
      be = clip16(rshift_half_up(longint'($signed(x.iq)) * c -
                                 longint'($signed(x.id)) * s, 24), sat);
      u  = al;
      v  = clip16(rshift_half_up(-al * (longint'(1) << 24) + 64'sd29058991 * be, 25), sat);
      w  = clip16(rshift_half_up(-al * (longint'(1) << 24) - 64'sd29058991 * be, 25), sat);
    end
    o.alpha = al[SB-1:0]; o.beta = be[SB-1:0];
    o.d = d[SB-1:0]; o.q = q[SB-1:0];
    o.u = u[SB-1:0]; o.v = v[SB-1:0]; o.w = w[SB-1:0];
    o.sat = sat;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  task automatic send_word(xform_in_t x, bit has_ans, xform_out_t ans);
    while (!quiet_gaps && $urandom_range(99) < 20) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= x.op;
    in_if.phase_u       <= x.pu;
    in_if.phase_v       <= x.pv;
    in_if.phase_w       <= x.pw;
    in_if.in_direct     <= x.id;
    in_if.in_quadrature <= x.iq;
    in_if.angle         <= x.ang;
    do @(posedge clk_i); while (!in_if.ready);
    // word taken at this edge
    dq_expected.push_back(has_ans ? ans : predict_dq(x));
  endtask

  function automatic xform_in_t rand_word();
    xform_in_t x;
    int pick;
    x.op = op_e'($urandom_range(1));
    x.pu = SB'($urandom); x.pv = SB'($urandom); x.pw = SB'($urandom);
    x.id = SB'($urandom); x.iq = SB'($urandom);
    pick = $urandom_range(9);
    // bias angles to the quadrant edges now and then
    if (pick == 0) x.ang = AB'($urandom_range(3) * QUARTER);
    else if (pick == 1) x.ang = AB'($urandom_range(3) * QUARTER + QUARTER - 1);
    else x.ang = AB'($urandom);
    // occasional full-scale samples to provoke clipping
    if ($urandom_range(7) == 0) begin
      x.pv = 16'h7fff; x.pw = 16'h8000;
      x.id = $urandom_range(1) ? 16'h7fff : 16'h8000;
      x.iq = $urandom_range(1) ? 16'h7fff : 16'h8000;
    end
    return x;
  endfunction

  function automatic xform_in_t mk(op_e op, int pu, int pv, int pw, int id, int iq, int ang);
    xform_in_t x;
    x.op = op; x.pu = SB'(pu); x.pv = SB'(pv); x.pw = SB'(pw);
    x.id = SB'(id); x.iq = SB'(iq); x.ang = AB'(ang);
    return x;
  endfunction

  function automatic xform_out_t ans(int al, int be, int d, int q, int u, int v, int w,
                                     bit sat);
    xform_out_t o;
    o.alpha = SB'(al); o.beta = SB'(be); o.d = SB'(d); o.q = SB'(q);
    o.u = SB'(u); o.v = SB'(v); o.w = SB'(w); o.sat = sat;
    return o;
  endfunction

  // Directed table. Typed answers only where obvious: zeros in, zeros out;
  // forward alpha copies phase U unclipped.
  dir_row_t dir_tbl[$];

  initial begin
    xform_out_t none;
    none = ans(0, 0, 0, 0, 0, 0, 0, 1'b0);
    dir_tbl = '{
      '{mk(OP_FWD, 0, 0, 0, 0, 0, 0),                 1'b1, none},
      '{mk(OP_INV, 0, 0, 0, 0, 0, 0),                 1'b1, none},
      '{mk(OP_FWD, 0, 0, 0, 16'h7fff, 16'h8000, 4095),1'b1, none},
      '{mk(OP_INV, 16'h7fff, 16'h8000, 16'h1234, 0, 0, 2048), 1'b1, none},
      '{mk(OP_FWD, 16'h7fff, 0, 0, 0, 0, 0),          1'b0, none},
      '{mk(OP_FWD, 16'h8000, 0, 0, 0, 0, 0),          1'b0, none},
      '{mk(OP_FWD, 1000, 16'h7fff, 16'h8000, 0, 0, 0),1'b0, none},
      '{mk(OP_FWD, 16'h8000, 16'h8000, 16'h7fff, 0, 0, 512), 1'b0, none},
      '{mk(OP_FWD, 16'h7fff, 16'h7fff, 16'h8000, 0, 0, 512), 1'b0, none},
      '{mk(OP_FWD, 16'h7fff, 16'h7fff, 16'h8000, 0, 0, 1024), 1'b0, none},
      '{mk(OP_FWD, 16'h1234, 16'h4321, 16'hbeef, 0, 0, 2048), 1'b0, none},
      '{mk(OP_FWD, 16'h5555, 16'haaaa, 16'h5555, 0, 0, 3072), 1'b0, none},
      '{mk(OP_FWD, 16'haaaa, 16'h5555, 16'haaaa, 16'hffff, 16'hffff, 4095), 1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'h7fff, 0, 0),          1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'h8000, 0, 0),          1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'h7fff, 16'h7fff, 512), 1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'h8000, 16'h8000, 512), 1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 0, 16'h7fff, 1024),       1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'h8000, 16'h7fff, 1536),1'b0, none},
      '{mk(OP_INV, 16'hffff, 16'hffff, 16'hffff, 16'h5555, 16'haaaa, 2048), 1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'haaaa, 16'h5555, 3072),1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'h4000, 16'hc000, 1023),1'b0, none},
      '{mk(OP_INV, 0, 0, 0, 16'h7fff, 16'h8000, 4095),1'b0, none}
    };
    // alpha copies phase U even at full scale
    dir_tbl[4].typed = 1'b1;
    dir_tbl[4].res = ans(16'h7fff, 0, 16'h7fff, 0, 0, 0, 0, 1'b0);
    dir_tbl[5].typed = 1'b1;
    dir_tbl[5].res = ans(16'h8000, 0, 16'h8000, 0, 0, 0, 0, 1'b0);
  end

  // Stimulus thread
  initial begin
    in_if.valid <= 1'b0;
    in_if.op <= OP_FWD;
    in_if.phase_u <= '0; in_if.phase_v <= '0; in_if.phase_w <= '0;
    in_if.in_direct <= '0; in_if.in_quadrature <= '0; in_if.angle <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      send_word(dir_tbl[i].stim, dir_tbl[i].typed, dir_tbl[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      xform_in_t x;
      // quiet stretch with back-to-back words on both sides
      quiet_gaps = (n >= 100 && n < 180);
      // long receiver hold-off while words keep coming
      if (n == 250) sink_hold = 1'b1;
      // sender drains the pipe fully once
      if (n == 400) begin
        in_if.valid <= 1'b0;
        while (dq_expected.size() != 0) @(posedge clk_i);
      end
      x = rand_word();
      send_word(x, 1'b0, predict_dq(x));
    end
    in_if.valid <= 1'b0;

    while (dq_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0 && dq_expected.size() == 0) begin
      $display("three_phase_dq_transform_top: match");
    end else begin
      $display("three_phase_dq_transform_top: mismatch");
    end
    $finish;
  end

  // Receiver ready: random stalls, one long hold-off counted in cycles
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold && hold_cnt < 60) begin
        hold_cnt++;
        out_if.ready <= 1'b0;
      end else begin
        sink_hold = 1'b0;
        out_if.ready <= quiet_gaps ? 1'b1 : ($urandom_range(99) >= 20);
      end
    end
  end

  // Checker: compare every taken word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (dq_expected.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected output word");
      end else begin
        xform_out_t e;
        e = dq_expected.pop_front();
        if (out_if.out_alpha !== e.alpha || out_if.out_beta !== e.beta ||
            out_if.out_direct !== e.d || out_if.out_quadrature !== e.q ||
            out_if.out_u !== e.u || out_if.out_v !== e.v ||
            out_if.out_w !== e.w || out_if.saturated !== e.sat) begin
          n_fail++;
          if (n_fail <= 10)
            $display("word diff: exp a%h b%h d%h q%h u%h v%h w%h s%b got a%h b%h d%h q%h u%h v%h w%h s%b",
                     e.alpha, e.beta, e.d, e.q, e.u, e.v, e.w, e.sat,
                     out_if.out_alpha, out_if.out_beta, out_if.out_direct,
                     out_if.out_quadrature, out_if.out_u, out_if.out_v,
                     out_if.out_w, out_if.saturated);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2ms;
    $display("three_phase_dq_transform_top: mismatch");
    $finish;
  end

endmodule
